// File: rtl/core/cli_pkg.sv
`timescale 1ns / 1ps

package cli_pkg;

  // field and port widths
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // default table shape
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // result region codes
  localparam logic [1:0] REGION_BELOW  = 2'd0;
  localparam logic [1:0] REGION_INSIDE = 2'd1;
  localparam logic [1:0] REGION_ABOVE  = 2'd2;

  // register index (word address)
  localparam logic [PADDR_W-3:0] REG_ENTRY_COUNT = '0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WHI,
    ST_MUL0,
    ST_MUL1,
    ST_SUM,
    ST_ABS,
    ST_DIV,
    ST_QUOT,
    ST_FIN
  } state_t;

endpackage

// File: rtl/core/cli_table.sv
`timescale 1ns / 1ps

module cli_table
  import cli_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(TABLE_DEPTH_DEF),
  parameter int DW    = 2 * VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/clamped_linear_interpolator.sv
// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_ready    opcode, entry_index, key_value, entry_value
// out       source     out_valid/out_ready  result_value, region
// cfg       APB slave  psel/penable/pready  paddr, pwdata, prdata (entry_count)
//
// A write beat is taken straight from idle. A query beat scans k breakpoints (one table
// read and compare per cycle, up to 64), then runs the weight, multiply, sum and abs
// steps, W restoring division steps (one per cycle, W the data width), quotient, finish.
// The single subtractor serves the scan compares, the weight differences and the divider.
// rst is synchronous; the table holds no reset value and must be written before use.
// A finished result waits in the output register; the next item is taken meanwhile,
// and a query only stalls at its end if that register is still full.
`timescale 1ns / 1ps

module clamped_linear_interpolator
  import cli_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      opcode,
  input  logic [INDEX_W-1:0]        entry_index,
  input  logic signed [FIELD_W-1:0] key_value,
  input  logic signed [FIELD_W-1:0] entry_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [FIELD_W-1:0] result_value,
  output logic [1:0]                region,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  localparam int EW   = (VALUE_WIDTH > FIELD_W) ? FIELD_W : VALUE_WIDTH;
  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MW   = 2 * EW;
  localparam int SW   = EW + 2;
  localparam int PW   = 2 * EW + 1;
  localparam int CW   = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
  localparam int CNTW = $clog2(EW);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(EW - 1);
  localparam logic signed [EW:0] SAT_MAX = (EW + 1)'((64'sd1 <<< (EW - 1)) - 64'sd1);
  localparam logic signed [EW:0] SAT_MIN = -SAT_MAX - (EW + 1)'(1);

  state_t state, state_next;
  logic   out_load;

  logic [COUNT_W-1:0] entry_count;

  // table port
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [MW-1:0] rd_data;
  logic signed [EW-1:0] rd_key, rd_sample;

  // query working registers
  logic signed [EW-1:0] key, lo_key, hi_key, lo_sample, hi_sample;
  logic [AW-1:0]        idx, last;
  logic [AW-1:0]        last_calc;
  logic signed [EW:0]   w;
  logic signed [PW-1:0] prod, acc, mag;
  logic [EW-1:0]        den, rem, dvd;
  logic                 neg;
  logic [CNTW-1:0]      cnt;
  logic signed [EW:0]   quot_s, quot_sat;
  logic signed [EW-1:0] res;
  logic [1:0]           res_region;

  // shared arithmetic
  logic signed [SW-1:0] sub_a, sub_b, diff;
  logic signed [EW:0]   mul_a;
  logic signed [EW-1:0] mul_b;
  logic                 scan_less;

  logic [CW-1:0] count_ext;

  // ---------------------------------------------------------------- table
  assign wr_en = in_valid && in_ready && (opcode == OP_WRITE) &&
                 (32'(entry_index) < 32'(TABLE_DEPTH));

  cli_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (MW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(entry_index)),
    .wr_data ({key_value[EW-1:0], entry_value[EW-1:0]}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_key    = rd_data[MW-1:EW];
  assign rd_sample = rd_data[EW-1:0];

  // prefetch the next entry while the current one is compared
  assign rd_addr = (state == ST_SCAN) ? idx + AW'(1) : '0;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= COUNT_W'(1);
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_ENTRY_COUNT) begin
      entry_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT) ? PDATA_W'(entry_count) : '0;

  // clamp the count to 1..TABLE_DEPTH and keep the last index
  assign count_ext = CW'(entry_count);

  always_comb begin
    if (count_ext == '0) begin
      last_calc = '0;
    end else if (count_ext >= CW'(TABLE_DEPTH)) begin
      last_calc = AW'(TABLE_DEPTH - 1);
    end else begin
      last_calc = AW'(count_ext - CW'(1));
    end
  end

  // ---------------------------------------------------------------- shared unit
  always_comb begin
    case (state)
      ST_SCAN: begin
        sub_a = SW'(key);
        sub_b = SW'(rd_key);
      end
      ST_WHI: begin
        sub_a = SW'(hi_key);
        sub_b = SW'(key);
      end
      ST_MUL0: begin
        sub_a = SW'(key);
        sub_b = SW'(lo_key);
      end
      ST_MUL1: begin
        sub_a = SW'(hi_key);
        sub_b = SW'(lo_key);
      end
      ST_DIV: begin
        sub_a = {1'b0, rem, dvd[EW-1]};
        sub_b = SW'(den);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign diff      = sub_a - sub_b;
  assign scan_less = diff[SW-1];

  assign mul_a = w;
  assign mul_b = (state == ST_MUL1) ? hi_sample : lo_sample;

  assign mag    = acc[PW-1] ? -acc : acc;
  assign quot_s = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});

  always_comb begin
    if (quot_s > SAT_MAX) begin
      quot_sat = SAT_MAX;
    end else if (quot_s < SAT_MIN) begin
      quot_sat = SAT_MIN;
    end else begin
      quot_sat = quot_s;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_load || (out_valid && !out_ready);
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && opcode == OP_QUERY) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_less) begin
          state_next = (idx == '0) ? ST_FIN : ST_WHI;
        end else if (idx == last) begin
          state_next = ST_FIN;
        end
      end
      ST_WHI:  state_next = ST_MUL0;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_SUM;
      ST_SUM:  state_next = ST_ABS;
      ST_ABS:  state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_QUOT;
        end
      end
      ST_QUOT: state_next = ST_FIN;
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid && opcode == OP_QUERY) begin
          key  <= key_value[EW-1:0];
          last <= last_calc;
          idx  <= '0;
        end
      end
      ST_SCAN: begin
        if (scan_less) begin
          if (idx == '0) begin
            res        <= rd_sample;
            res_region <= REGION_BELOW;
          end else begin
            hi_key    <= rd_key;
            hi_sample <= rd_sample;
          end
        end else begin
          lo_key    <= rd_key;
          lo_sample <= rd_sample;
          if (idx == last) begin
            res        <= rd_sample;
            res_region <= REGION_ABOVE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
      end
      ST_WHI: begin
        w <= diff[EW:0];
      end
      ST_MUL0: begin
        prod <= mul_a * mul_b;
        w    <= diff[EW:0];
      end
      ST_MUL1: begin
        acc  <= prod;
        prod <= mul_a * mul_b;
        den  <= diff[EW-1:0];
      end
      ST_SUM: begin
        acc <= acc + prod;
      end
      ST_ABS: begin
        neg <= acc[PW-1];
        rem <= mag[2*EW-1:EW];
        dvd <= mag[EW-1:0];
        cnt <= '0;
      end
      ST_DIV: begin
        // restoring step: shift in the next dividend bit, keep the quotient bit
        if (!diff[SW-1]) begin
          rem <= diff[EW-1:0];
        end else begin
          rem <= {rem[EW-2:0], dvd[EW-1]};
        end
        dvd <= {dvd[EW-2:0], !diff[SW-1]};
        cnt <= cnt + CNTW'(1);
      end
      ST_QUOT: begin
        res        <= quot_sat[EW-1:0];
        res_region <= REGION_INSIDE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_value <= FIELD_W'(res);
      region       <= res_region;
    end
  end

  // ---------------------------------------------------------------- checks
  a_query_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_QUERY |=> state == ST_SCAN)
    else $error("query beat did not start the scan");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_WRITE |=> state == ST_IDLE)
    else $error("write beat left the idle state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> idx <= last)
    else $error("scan index ran past the last entry in use");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> den != '0)
    else $error("division with a zero breakpoint gap");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("result presented outside the finish state");

endmodule
